// ----- hw/rtl/epst_pkg.sv -----
package epst_pkg;

  // Tick total width and the fixed field widths of the block.
  localparam int TICK_W    = 32;
  localparam int STEP_W    = 16;
  localparam int COUNTER_W = 16;
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Ticks per logical step, kept as a power of two so the divide is a shift.
  localparam int TPS_SHIFT      = 2;
  localparam int TICKS_PER_STEP = 1 << TPS_SHIFT;

  // The remainder unit handles step differences of STEP_W + 1 bits.
  localparam int MOD_BITS  = STEP_W;
  localparam int MOD_CNT_W = $clog2(MOD_BITS);
  localparam int RANGE_W   = STEP_W + 1;

  // Command codes carried on the input kind field.
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESET    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_STEP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLIC_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIR = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_PREP,
    ST_ITER,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic prep;
    logic iter;
    logic fin;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic use_div;
    logic iter_last;
  } dp_status_t;

endpackage

// ----- hw/rtl/epst_ctrl.sv -----
module epst_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  epst_pkg::dp_status_t   status,
  output epst_pkg::ctrl_cmd_t    cmd
);
  import epst_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_TICK;
        end
      end
      ST_TICK: begin
        state_nxt = status.is_sample ? ST_PREP : ST_EMIT;
      end
      ST_PREP: begin
        state_nxt = status.use_div ? ST_ITER : ST_FIN;
      end
      ST_ITER: begin
        if (status.iter_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.load = (state_r == ST_IDLE) && in_valid;
    cmd.tick = (state_r == ST_TICK);
    cmd.prep = (state_r == ST_PREP);
    cmd.iter = (state_r == ST_ITER);
    cmd.fin  = (state_r == ST_FIN);
    cmd.emit = (state_r == ST_EMIT) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/epst_dp.sv -----
module epst_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  epst_pkg::ctrl_cmd_t                 cmd,
  output epst_pkg::dp_status_t                status,
  input  logic [epst_pkg::FUNC_W-1:0]         in_func,
  input  logic [epst_pkg::COUNTER_W-1:0]      in_counter,
  input  logic signed [epst_pkg::STEP_W-1:0]  in_new_step,
  input  logic                                cfg_we,
  input  logic [epst_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [epst_pkg::CFG_DAT_W-1:0]      cfg_dat,
  output logic signed [epst_pkg::TICK_W-1:0]  out_tick,
  output logic signed [epst_pkg::STEP_W-1:0]  out_step
);
  import epst_pkg::*;

  // Configuration.
  logic signed [STEP_W-1:0] min_step_r;
  logic signed [STEP_W-1:0] max_step_r;
  logic                     cyclic_r;
  logic                     reverse_r;

  // Captured item.
  logic [FUNC_W-1:0]        func_r;
  logic [COUNTER_W-1:0]     counter_r;
  logic signed [STEP_W-1:0] new_step_r;

  // Tracker state.
  logic [COUNTER_W-1:0]     last_sample_r, last_sample_nxt;
  logic signed [TICK_W-1:0] tick_total_r, tick_total_nxt;
  logic signed [STEP_W-1:0] step_r, step_nxt;

  // Remainder unit.
  logic signed [STEP_W-1:0] raw_r;
  logic                     xneg_r;
  logic [MOD_BITS-1:0]      dvd_r, dvd_nxt;
  logic [RANGE_W-1:0]       range_r, range_nxt;
  logic [RANGE_W-1:0]       rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0]     cnt_r, cnt_nxt;

  // Output register.
  logic signed [TICK_W-1:0] out_tick_r;
  logic signed [STEP_W-1:0] out_step_r;

  // Tick update terms.
  logic [COUNTER_W-1:0]     diff;
  logic [COUNTER_W-1:0]     diff_dir;
  logic signed [TICK_W-1:0] delta;
  logic signed [TICK_W-1:0] set_ticks;

  // Preparation terms.
  logic signed [TICK_W-1:0] biased;
  logic signed [TICK_W-1:0] quot;
  logic signed [STEP_W-1:0] raw;
  logic signed [RANGE_W-1:0] xdiff;
  logic [RANGE_W-1:0]       xmag;
  logic [RANGE_W:0]         range_full;
  logic                     range_ok;

  // Iteration and finish terms.
  logic [RANGE_W:0]         rem_shift;
  logic [RANGE_W-1:0]       rem_wrap;
  logic [STEP_W-1:0]        wrapped;
  logic signed [STEP_W-1:0] clamped;

  assign range_ok = (max_step_r >= min_step_r);

  assign status.is_sample = (func_r == FUNC_SAMPLE);
  assign status.use_div   = cyclic_r && range_ok;
  assign status.iter_last = (cnt_r == MOD_CNT_W'(MOD_BITS - 1));

  always_comb begin
    diff      = counter_r - last_sample_r;
    diff_dir  = reverse_r ? (COUNTER_W'(0) - diff) : diff;
    delta     = TICK_W'(signed'(diff_dir));
    set_ticks = TICK_W'(new_step_r) <<< TPS_SHIFT;

    // Truncate toward zero: bias negative totals before the arithmetic shift.
    biased = tick_total_r + (tick_total_r[TICK_W-1] ? TICK_W'(TICKS_PER_STEP - 1) : '0);
    quot   = biased >>> TPS_SHIFT;
    raw    = quot[STEP_W-1:0];
    xdiff  = RANGE_W'(raw) - RANGE_W'(min_step_r);
    xmag   = xdiff[RANGE_W-1] ? (RANGE_W'(0) - xdiff) : xdiff;
    range_full = (RANGE_W+1)'(max_step_r) - (RANGE_W+1)'(min_step_r) + (RANGE_W+1)'(1);

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    rem_shift = {rem_r, dvd_r[MOD_BITS-1]};

    // A negative difference with a nonzero remainder folds back from the top.
    rem_wrap = (xneg_r && (rem_r != '0)) ? (range_r - rem_r) : rem_r;
    wrapped  = rem_wrap[STEP_W-1:0] + min_step_r;

    if (raw_r < min_step_r) begin
      clamped = min_step_r;
    end else if (raw_r > max_step_r) begin
      clamped = max_step_r;
    end else begin
      clamped = raw_r;
    end
  end

  always_comb begin
    last_sample_nxt = last_sample_r;
    tick_total_nxt  = tick_total_r;
    step_nxt        = step_r;
    dvd_nxt         = dvd_r;
    range_nxt       = range_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;

    if (cmd.tick) begin
      case (func_r)
        FUNC_SAMPLE: begin
          last_sample_nxt = counter_r;
          tick_total_nxt  = tick_total_r + delta;
        end
        FUNC_RESET: begin
          tick_total_nxt = '0;
          step_nxt       = '0;
        end
        FUNC_SET_STEP: begin
          tick_total_nxt = set_ticks;
          step_nxt       = new_step_r;
        end
        default: begin
        end
      endcase
    end

    if (cmd.prep) begin
      dvd_nxt   = xmag[MOD_BITS-1:0];
      range_nxt = range_full[RANGE_W-1:0];
      rem_nxt   = '0;
      cnt_nxt   = '0;
    end

    if (cmd.iter) begin
      if (rem_shift >= {1'b0, range_r}) begin
        rem_nxt = RANGE_W'(rem_shift - {1'b0, range_r});
      end else begin
        rem_nxt = rem_shift[RANGE_W-1:0];
      end
      dvd_nxt = {dvd_r[MOD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + MOD_CNT_W'(1);
    end

    // With max below min the step is held.
    if (cmd.fin && range_ok) begin
      step_nxt = cyclic_r ? signed'(wrapped) : clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_step_r    <= '0;
      max_step_r    <= STEP_W'(100);
      cyclic_r      <= 1'b1;
      reverse_r     <= 1'b0;
      last_sample_r <= '0;
      tick_total_r  <= '0;
      step_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MIN_STEP:    min_step_r <= signed'(cfg_dat[STEP_W-1:0]);
          REG_MAX_STEP:    max_step_r <= signed'(cfg_dat[STEP_W-1:0]);
          REG_CYCLIC_MODE: cyclic_r   <= cfg_dat[0];
          REG_REVERSE_DIR: reverse_r  <= cfg_dat[0];
          default: begin
          end
        endcase
      end
      last_sample_r <= last_sample_nxt;
      tick_total_r  <= tick_total_nxt;
      step_r        <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r     <= in_func;
      counter_r  <= in_counter;
      new_step_r <= in_new_step;
    end
    if (cmd.prep) begin
      raw_r  <= raw;
      xneg_r <= xdiff[RANGE_W-1];
    end
    dvd_r   <= dvd_nxt;
    range_r <= range_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    if (cmd.emit) begin
      out_tick_r <= tick_total_r;
      out_step_r <= step_r;
    end
  end

  assign out_tick = out_tick_r;
  assign out_step = out_step_r;

endmodule

// ----- hw/rtl/encoder_step_position_tracker_unit.sv -----
// Channel   Direction  Handshake                Contents
// in_       slave      in_tvalid / in_tready    tuser: func; tdata: counter_value, new_step
// out_      master     out_tvalid / out_tready  tdata: tick_count, step_count
// cfg_      slave      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Items are handled one at a time. A counter sample in cyclic mode goes through
// accept, tick update, preparation, one step of the restoring remainder unit per
// dividend bit, step update and hand-off to the output register. Clamping mode
// skips the remainder steps; a position reset or step load goes from tick update to hand-off.
// Reset (rst_n, synchronous, active low) restores the register defaults and
// clears the position. A stalled output holds its result while the next item
// is already accepted; that item then waits only at its final hand-off.
module encoder_step_position_tracker_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic [31:0] in_tdata,   // [15:0] counter_value, [31:16] new_step
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] tick_count, [47:32] step_count
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import epst_pkg::*;

  ctrl_cmd_t                cmd;
  dp_status_t               status;
  logic signed [TICK_W-1:0] tick_count;
  logic signed [STEP_W-1:0] step_count;

  // The user must write registers only while idle; the block itself does not enforce it, so writes are always taken.
  assign cfg_ready = 1'b1;

  // The controller sequences each item and owns both handshakes.
  epst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the tracker state, the remainder
  // unit used for cyclic wrapping, and the output register.
  epst_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_func     (in_tuser),
    .in_counter  (in_tdata[15:0]),
    .in_new_step (signed'(in_tdata[31:16])),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_dat     (cfg_data),
    .out_tick    (tick_count),
    .out_step    (step_count)
  );

  assign out_tdata = {step_count, tick_count};

endmodule
